// ----- hw/rtl/ctwl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ctwl_pkg: connection table wildcard lookup package
// Shared sizes, item structs and command codes for the lookup block.
// ----------------------------------------------------------------------------
package ctwl_pkg;

  // Number of connection slots held in the table.
  localparam int TABLE_DEPTH = 64;

  // Fixed field widths of the item formats.
  localparam int SLOT_W  = 6;
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int SCORE_W = 2;

  // Table index width and a width that holds both a slot field and an index.
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int WIDE_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int CMP_W  = WIDE_W + 1;

  // Score used while no entry has matched yet.
  localparam logic [SCORE_W-1:0] NO_MATCH_SCORE = 2'd3;

  // Input item.
  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic              entry_valid;
    logic [ADDR_W-1:0] local_addr;
    logic [PORT_W-1:0] local_port;
    logic [ADDR_W-1:0] foreign_addr;
    logic [PORT_W-1:0] foreign_port;
    logic              allow_wildcard;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic               found;
    logic [SLOT_W-1:0]  match_slot;
    logic [SCORE_W-1:0] wildcard_count;
  } out_item_t;

  // One stored connection, also used as the lookup key.
  typedef struct packed {
    logic [ADDR_W-1:0] local_addr;
    logic [PORT_W-1:0] local_port;
    logic [ADDR_W-1:0] foreign_addr;
    logic [PORT_W-1:0] foreign_port;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Command codes decided by the front end.
  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_INSTALL = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_IGNORE  = 2'd3
  } op_t;

  // Command passed from the front end to the back end.
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] slot;
    entry_t           entry;
    logic             allow_wildcard;
  } cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ctwl_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ctwl_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ctwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hw/rtl/ctwl_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ctwl_front: input front end
// Accepts input items, decodes them into commands and queues them in a
// two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module ctwl_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ctwl_pkg::in_item_t in_data,
  output logic                   cmd_valid,
  input  wire logic              cmd_ready,
  output ctwl_pkg::cmd_t         cmd
);
  import ctwl_pkg::*;

  logic [WIDE_W-1:0] slot_wide;
  logic              slot_in_range;
  cmd_t              cmd_in;
  logic              push;
  logic              pop;
  cmd_t              q_mem_r [2];
  logic              wr_ptr_r;
  logic              wr_ptr_nxt;
  logic              rd_ptr_r;
  logic              rd_ptr_nxt;
  logic [1:0]        count_r;
  logic [1:0]        count_nxt;

  // Classify the item: lookup, install, remove, or a write outside the table.
  assign slot_wide     = WIDE_W'(in_data.slot);
  assign slot_in_range = CMP_W'(in_data.slot) < CMP_W'(TABLE_DEPTH);

  always_comb begin
    cmd_in.slot                = slot_wide[IDX_W-1:0];
    cmd_in.entry.local_addr    = in_data.local_addr;
    cmd_in.entry.local_port    = in_data.local_port;
    cmd_in.entry.foreign_addr  = in_data.foreign_addr;
    cmd_in.entry.foreign_port  = in_data.foreign_port;
    cmd_in.allow_wildcard      = in_data.allow_wildcard;
    if (in_data.mode) begin
      cmd_in.op = OP_LOOKUP;
    end else if (!slot_in_range) begin
      cmd_in.op = OP_IGNORE;
    end else if (in_data.entry_valid) begin
      cmd_in.op = OP_INSTALL;
    end else begin
      cmd_in.op = OP_REMOVE;
    end
  end

  // Queue control.
  assign in_ready  = (count_r != 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ctwl_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ctwl_back: table back end
// Owns the connection table, executes writes and scans the whole table for
// lookups, one entry per cycle, into an output register.
// ----------------------------------------------------------------------------
module ctwl_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire ctwl_pkg::cmd_t     cmd,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ctwl_pkg::out_item_t     out_data
);
  import ctwl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic               ok;
    logic [SCORE_W-1:0] wc;
  } side_t;

  state_t             state_r;
  state_t             state_nxt;
  logic               valid_r [TABLE_DEPTH];
  logic [IDX_W-1:0]   issue_r;
  logic [IDX_W-1:0]   issue_nxt;
  logic               cmp_vld_r;
  logic               cmp_live_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  entry_t             key_r;
  logic               allow_r;
  logic [SCORE_W-1:0] best_score_r;
  logic [SCORE_W-1:0] best_score_nxt;
  logic [IDX_W-1:0]   best_slot_r;
  logic [IDX_W-1:0]   best_slot_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_item_t          out_data_r;
  out_item_t          out_data_nxt;

  logic               out_free;
  logic               take;
  logic               start;
  logic               load_out;
  logic               valid_set;
  logic               valid_clr;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             ent;
  side_t              side_l;
  side_t              side_f;
  logic               fport_ok;
  logic [SCORE_W-1:0] score;
  logic               hit;
  logic               better;
  logic               found_nxt;
  logic [WIDE_W-1:0]  best_wide;

  // Wildcard score of one address side; ok is low on a hard mismatch.
  function automatic side_t side_score(input logic [ADDR_W-1:0] e_addr,
                                       input logic [ADDR_W-1:0] k_addr);
    side_t res;
    res.ok = 1'b1;
    res.wc = '0;
    if (e_addr != '0) begin
      if (k_addr == '0) begin
        res.wc = 2'd1;
      end else if (e_addr != k_addr) begin
        res.ok = 1'b0;
      end
    end else if (k_addr != '0) begin
      res.wc = 2'd1;
    end
    return res;
  endfunction

  // Entry storage.
  ctwl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.slot),
    .wdata (cmd.entry),
    .raddr (issue_r),
    .rdata (ram_rdata)
  );

  // Compare the entry read last cycle against the key.
  assign ent      = entry_t'(ram_rdata);
  assign side_l   = side_score(ent.local_addr, key_r.local_addr);
  assign side_f   = side_score(ent.foreign_addr, key_r.foreign_addr);
  assign fport_ok = (ent.foreign_addr == '0) || (key_r.foreign_addr == '0) ||
                    (ent.foreign_port == key_r.foreign_port);
  assign score    = side_l.wc + side_f.wc;
  assign hit      = cmp_live_r && (ent.local_port == key_r.local_port) &&
                    side_l.ok && side_f.ok && fport_ok &&
                    ((score == '0) || allow_r);
  assign better   = cmp_vld_r && hit && (score < best_score_r);

  // Best match so far, with ties kept on the lower slot.
  always_comb begin
    best_score_nxt = better ? score : best_score_r;
    best_slot_nxt  = better ? cmp_idx_r : best_slot_r;
    found_nxt      = (best_score_nxt != NO_MATCH_SCORE);
    best_wide      = WIDE_W'(best_slot_nxt);
  end

  // Sequencer for writes and table scans.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    issue_nxt    = issue_r;
    cmd_ready    = 1'b0;
    take         = 1'b0;
    start        = 1'b0;
    load_out     = 1'b0;
    valid_set    = 1'b0;
    valid_clr    = 1'b0;
    ram_we       = 1'b0;
    out_data_nxt = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd_ready = out_free;
        take      = cmd_valid && out_free;
        if (take) begin
          unique case (cmd.op) inside
            OP_LOOKUP: begin
              start     = 1'b1;
              issue_nxt = '0;
              state_nxt = S_SCAN;
            end
            OP_INSTALL: begin
              ram_we    = 1'b1;
              valid_set = 1'b1;
              load_out  = 1'b1;
            end
            OP_REMOVE: begin
              valid_clr = 1'b1;
              load_out  = 1'b1;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        issue_nxt = issue_r + IDX_W'(1);
        if (issue_r == IDX_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        load_out                    = 1'b1;
        out_data_nxt.found          = found_nxt;
        out_data_nxt.match_slot     = found_nxt ? best_wide[SLOT_W-1:0] : '0;
        out_data_nxt.wildcard_count = found_nxt ? best_score_nxt : '0;
        state_nxt                   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state, valid bits and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      issue_r     <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= (state_r == S_SCAN);
      issue_r     <= issue_nxt;
      if (valid_set) begin
        valid_r[cmd.slot] <= 1'b1;
      end else if (valid_clr) begin
        valid_r[cmd.slot] <= 1'b0;
      end
    end
  end

  // Key, compare stage and best-match payload.
  always_ff @(posedge clk) begin
    cmp_idx_r  <= issue_r;
    cmp_live_r <= valid_r[issue_r];
    if (start) begin
      key_r        <= cmd.entry;
      allow_r      <= cmd.allow_wildcard;
      best_score_r <= NO_MATCH_SCORE;
      best_slot_r  <= '0;
    end else begin
      best_score_r <= best_score_nxt;
      best_slot_r  <= best_slot_nxt;
    end
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- hw/rtl/connection_table_wildcard_lookup_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// connection_table_wildcard_lookup_top: connection table with wildcard lookup
// Stores connection entries and finds the entry needing fewest wildcards.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the in_ channel (valid/ready); mode 0 installs or removes
//   one slot, mode 1 looks up a key. Every item gives exactly one result on
//   the out_ channel (valid/ready); writes report found = 0.
//   The front end queues up to two items, so the input keeps taking items
//   while the back end is busy or a result waits in the output register.
//   A write is done when the back end takes it in the idle state. A
//   lookup reads every table slot from the entry RAM, one per cycle, in the
//   scan state, then loads its result into the output register in the
//   flush state; the single RAM read port sets the scan rate. A write's
//   result passes the front-end queue and then the output register.
//   Reset clears all slot valid bits at once; the entry RAM holds no reset
//   value and needs no clearing pass. While the receiver stalls, the result
//   is held, the back end waits, and the input stalls once the queue fills.
// ----------------------------------------------------------------------------
module connection_table_wildcard_lookup_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ctwl_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ctwl_pkg::out_item_t       out_data
);
  import ctwl_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Front end: accept and classify.
  ctwl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Back end: table writes and scans.
  ctwl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/ctwl_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ctwl_checker: port checker for the lookup block
// Watches the top-level ports and flags result and ordering errors.
// ----------------------------------------------------------------------------
module ctwl_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire ctwl_pkg::out_item_t  out_data
);
  import ctwl_pkg::*;

  logic       in_xfer;
  logic       out_xfer;
  logic [3:0] pending_r;
  logic [3:0] pending_nxt;

  // Count items accepted whose result has not been transferred yet.
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r + 4'(in_xfer) - 4'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // A stalled result stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A result never appears without an outstanding item.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 4'd0)
    else $error("result without an accepted item");

  // A miss reports zero slot and zero wildcards.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      out_data.match_slot == '0 && out_data.wildcard_count == '0)
    else $error("miss with nonzero slot or count");

  // A hit never reports the no-match score.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.wildcard_count != NO_MATCH_SCORE)
    else $error("hit with impossible wildcard count");

  // No result is offered right after reset.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind connection_table_wildcard_lookup_top ctwl_checker u_ctwl_checker (.*);
`default_nettype wire
